// File: sv/hmng_pkg.sv
// shared types, constants and reset values for the heightmap normal generator
`timescale 1ns / 1ps
package hmng_pkg;

   localparam int MAX_WIDTH_DEFAULT   = 1024;
   localparam int JOB_QUEUE_DEPTH     = 4;
   localparam int SAMPLE_BITS         = 16;
   localparam int MAP_WIDTH_BITS      = 11;
   localparam int MAP_HEIGHT_BITS     = 16;
   localparam int SCALE_BITS          = 16;
   localparam int COLUMN_BITS         = 10;
   localparam int ROW_BITS            = 16;
   localparam int DIFF_BITS           = 18;
   localparam int CSR_ADDR_BITS       = 4;
   localparam int CSR_DATA_BITS       = 32;

   localparam logic [MAP_WIDTH_BITS-1:0]  MAP_WIDTH_RESET   = 11'd255;
   localparam logic [MAP_HEIGHT_BITS-1:0] MAP_HEIGHT_RESET  = 16'd255;
   localparam logic [SCALE_BITS-1:0]      SLOPE_SCALE_RESET = 16'd12800;

   localparam logic [1:0] REG_MAP_WIDTH   = 2'd0;
   localparam logic [1:0] REG_MAP_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_SLOPE_SCALE = 2'd2;

   typedef struct packed {
      logic signed [DIFF_BITS-1:0] dx;
      logic signed [DIFF_BITS-1:0] dz;
      logic [COLUMN_BITS-1:0]      col;
      logic [ROW_BITS-1:0]         row;
      logic                        last;
      logic                        eom;
   } hmng_job_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_READ,
      FR_EMIT
   } hmng_front_state_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_MUL_X,
      BK_MUL_Z,
      BK_SQ_X,
      BK_SQ_Z,
      BK_SUM,
      BK_ROOT,
      BK_DIV_LOAD,
      BK_DIV,
      BK_DONE
   } hmng_back_state_type;

endpackage

// File: sv/hmng_if.sv
// beat channels for height samples in and normals out
`timescale 1ns / 1ps
interface hmng_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] height_sample;
   modport source (output valid, output height_sample, input ready);
   modport sink (input valid, input height_sample, output ready);
endinterface

interface hmng_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] normal_x;
   logic [14:0]        normal_y;
   logic signed [15:0] normal_z;
   logic [9:0]         cell_column;
   logic [15:0]        cell_row;
   logic               last_of_run;
   logic               end_of_map;
   modport source (output valid, output normal_x, output normal_y, output normal_z,
                   output cell_column, output cell_row, output last_of_run,
                   output end_of_map, input ready);
   modport sink (input valid, input normal_x, input normal_y, input normal_z,
                 input cell_column, input cell_row, input last_of_run,
                 input end_of_map, output ready);
endinterface

// File: sv/hmng_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module hmng_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: sv/hmng_front.sv
// front end: sample intake, line store update, neighbour window and job issue
`timescale 1ns / 1ps
module hmng_front #(
   parameter int MAX_WIDTH = hmng_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   hmng_req_if.sink                               req_if,
   input  logic [hmng_pkg::MAP_WIDTH_BITS-1:0]    map_width,
   input  logic [hmng_pkg::MAP_HEIGHT_BITS-1:0]   map_height,
   output logic                                   ram_we,
   output logic [$clog2(MAX_WIDTH)-1:0]           ram_waddr,
   output logic [2*hmng_pkg::SAMPLE_BITS-1:0]     ram_wdata,
   output logic [$clog2(MAX_WIDTH)-1:0]           ram_raddr,
   input  logic [2*hmng_pkg::SAMPLE_BITS-1:0]     ram_rdata,
   output logic                                   push_valid,
   input  logic                                   push_ready,
   output hmng_pkg::hmng_job_type                 push_job
);
   import hmng_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam logic [1:0] SLOT_INNER  = 2'd0;
   localparam logic [1:0] SLOT_RIGHT  = 2'd1;
   localparam logic [1:0] SLOT_BOTTOM = 2'd2;
   localparam logic [1:0] SLOT_CORNER = 2'd3;

   hmng_front_state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0] s_ff, u_ff, m_ff, p_ff;
   logic [SAMPLE_BITS-1:0] l0_ff, l1_ff, l2_ff, l3_ff;
   logic [CW-1:0]          c_ff, column_count_ff;
   logic [ROW_BITS-1:0]    r_ff, row_count_ff;
   logic [1:0]             slot_ff;

   logic [CW-1:0]          wm1, c_cl, x_sel;
   logic [ROW_BITS-1:0]    hm1, r_cl, y_sel;
   logic [3:0]             slot_set;
   logic                   slot_last, advance, step_done;
   logic [SAMPLE_BITS-1:0] zl, zc, zr, zu, zd;

   function automatic logic signed [DIFF_BITS-1:0] mirror_diff(
      input logic                   first,
      input logic                   last,
      input logic [SAMPLE_BITS-1:0] a,
      input logic [SAMPLE_BITS-1:0] ctr,
      input logic [SAMPLE_BITS-1:0] b
   );
      logic signed [DIFF_BITS:0] sa, sc, sb, rv;
      sa = $signed({3'b000, a});
      sc = $signed({3'b000, ctr});
      sb = $signed({3'b000, b});
      if (first) begin
         rv = sc - sb;
         rv = rv + rv;
      end else if (last) begin
         rv = sa - sc;
         rv = rv + rv;
      end else begin
         rv = sa - sb;
      end
      return rv[DIFF_BITS-1:0];
   endfunction

   // effective map size
   always_comb begin
      if (map_width < MAP_WIDTH_BITS'(2)) begin
         wm1 = CW'(1);
      end else if (32'(map_width) > MAX_WIDTH) begin
         wm1 = CW'(MAX_WIDTH - 1);
      end else begin
         wm1 = CW'(map_width - MAP_WIDTH_BITS'(1));
      end
      if (map_height < MAP_HEIGHT_BITS'(2)) begin
         hm1 = ROW_BITS'(1);
      end else begin
         hm1 = map_height - MAP_HEIGHT_BITS'(1);
      end
      c_cl = (column_count_ff > wm1) ? wm1 : column_count_ff;
      r_cl = (row_count_ff > hm1) ? hm1 : row_count_ff;
   end

   assign slot_set[SLOT_INNER]  = (c_ff != '0) && (r_ff != '0);
   assign slot_set[SLOT_RIGHT]  = (r_ff != '0) && (c_ff == wm1);
   assign slot_set[SLOT_BOTTOM] = (r_ff == hm1) && (c_ff != '0);
   assign slot_set[SLOT_CORNER] = (r_ff == hm1) && (c_ff == wm1);

   always_comb begin
      x_sel     = c_ff;
      y_sel     = r_ff;
      zl        = '0;
      zc        = '0;
      zr        = '0;
      zu        = '0;
      zd        = '0;
      slot_last = 1'b1;
      case (slot_ff)
         SLOT_INNER: begin
            x_sel     = c_ff - CW'(1);
            y_sel     = r_ff - ROW_BITS'(1);
            zl        = p_ff;
            zc        = l1_ff;
            zr        = m_ff;
            zu        = l0_ff;
            zd        = l2_ff;
            slot_last = (slot_set[3:1] == 3'b000);
         end
         SLOT_RIGHT: begin
            y_sel     = r_ff - ROW_BITS'(1);
            zl        = l1_ff;
            zc        = m_ff;
            zu        = u_ff;
            zd        = s_ff;
            slot_last = (slot_set[3:2] == 2'b00);
         end
         SLOT_BOTTOM: begin
            x_sel     = c_ff - CW'(1);
            zl        = l3_ff;
            zc        = l2_ff;
            zr        = s_ff;
            zu        = l1_ff;
            slot_last = !slot_set[SLOT_CORNER];
         end
         default: begin
            zl        = l2_ff;
            zc        = s_ff;
            zu        = m_ff;
         end
      endcase
   end

   assign push_job.dx   = mirror_diff(x_sel == '0, x_sel == wm1, zl, zc, zr);
   assign push_job.dz   = mirror_diff(y_sel == hm1, y_sel == '0, zd, zc, zu);
   assign push_job.col  = COLUMN_BITS'(x_sel);
   assign push_job.row  = y_sel;
   assign push_job.last = slot_last;
   assign push_job.eom  = (slot_ff == SLOT_CORNER);

   assign push_valid = (state_ff == FR_EMIT) && slot_set[slot_ff];
   assign advance    = !slot_set[slot_ff] || push_ready;
   assign step_done  = (state_ff == FR_EMIT) && advance && (slot_ff == SLOT_CORNER);

   assign req_if.ready = (state_ff == FR_IDLE);
   assign ram_raddr    = c_cl;
   assign ram_we       = (state_ff == FR_READ);
   assign ram_waddr    = c_ff;
   assign ram_wdata    = {ram_rdata[SAMPLE_BITS-1:0], s_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FR_IDLE: begin
            if (req_if.valid) begin
               state_in = FR_READ;
            end
         end
         FR_READ: begin
            state_in = FR_EMIT;
         end
         FR_EMIT: begin
            if (step_done) begin
               state_in = FR_IDLE;
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= FR_IDLE;
         column_count_ff <= '0;
         row_count_ff    <= '0;
         slot_ff         <= SLOT_INNER;
         l0_ff           <= '0;
         l1_ff           <= '0;
         l2_ff           <= '0;
         l3_ff           <= '0;
         p_ff            <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == FR_READ) begin
            slot_ff <= SLOT_INNER;
         end else if (state_ff == FR_EMIT && advance) begin
            slot_ff <= slot_ff + 2'd1;
         end
         if (step_done) begin
            p_ff  <= l1_ff;
            l0_ff <= u_ff;
            l1_ff <= m_ff;
            l3_ff <= l2_ff;
            l2_ff <= s_ff;
            if (c_ff == wm1) begin
               column_count_ff <= '0;
               row_count_ff    <= (r_ff == hm1) ? '0 : r_ff + ROW_BITS'(1);
            end else begin
               column_count_ff <= c_ff + CW'(1);
               row_count_ff    <= r_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == FR_IDLE && req_if.valid) begin
         s_ff <= req_if.height_sample;
         c_ff <= c_cl;
         r_ff <= r_cl;
      end
      if (state_ff == FR_READ) begin
         u_ff <= ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
         m_ff <= ram_rdata[SAMPLE_BITS-1:0];
      end
   end

   a_eom_is_last: assert property (@(posedge clock) disable iff (reset)
      push_valid && push_job.eom |-> push_job.last)
      else $error("corner job not flagged as last");

   a_step_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == FR_READ |=> state_ff == FR_EMIT && slot_ff == SLOT_INNER)
      else $error("job issue did not start at the first slot");
endmodule

// File: sv/hmng_queue.sv
// small job queue between front and back
`timescale 1ns / 1ps
module hmng_queue #(
   parameter int DEPTH = hmng_pkg::JOB_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  hmng_pkg::hmng_job_type push_job,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output hmng_pkg::hmng_job_type pop_job
);
   import hmng_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   hmng_job_type   slots_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0]  count_ff;
   logic           do_push, do_pop;

   assign push_ready = (count_ff != NW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + NW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - NW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(DEPTH))
      else $error("job queue overfilled");
endmodule

// File: sv/hmng_back.sv
// back end: slope scaling, vector length by bit-serial root, per-component division
`timescale 1ns / 1ps
module hmng_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [hmng_pkg::SCALE_BITS-1:0]   slope_scale,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  hmng_pkg::hmng_job_type            pop_job,
   hmng_rsp_if.source                        rsp_if
);
   import hmng_pkg::*;

   localparam logic [1:0]  COMP_X   = 2'd0;
   localparam logic [1:0]  COMP_Y   = 2'd1;
   localparam logic [1:0]  COMP_Z   = 2'd2;
   localparam logic [30:0] UP_MAG   = 31'd1 << 23;
   localparam logic [63:0] UP_SQ    = 64'd1 << 46;
   localparam logic [63:0] BIT_INIT = 64'd1 << 62;

   hmng_back_state_type state_ff, state_in;

   hmng_job_type  job_ff;
   logic [30:0]   ax_ff, az_ff;
   logic [61:0]   sq_ff;
   logic [63:0]   acc_ff, n_ff, res_ff, bit_ff;
   logic [4:0]    cnt_ff;
   logic [1:0]    comp_ff;
   logic [45:0]   rem_ff, dv_ff;
   logic [14:0]   q_ff;
   logic [15:0]   nx_ff, nz_ff;
   logic [14:0]   ny_ff;

   logic                 out_valid_ff;
   logic signed [15:0]   out_x_ff, out_z_ff;
   logic [14:0]          out_y_ff;
   logic [9:0]           out_col_ff;
   logic [15:0]          out_row_ff;
   logic                 out_last_ff, out_eom_ff;

   logic [17:0] mul_d;
   logic [33:0] prod;
   logic [30:0] sq_op, mag;
   logic [61:0] sq;
   logic [63:0] trial;
   logic        root_ge, div_ge, load_out, div_end;
   logic [31:0] root;
   logic [14:0] q_next;
   logic [15:0] q_signed;

   function automatic logic [17:0] abs_diff(input logic signed [17:0] d);
      return d[17] ? 18'(-d) : 18'(d);
   endfunction

   assign mul_d = (state_ff == BK_MUL_X) ? abs_diff(job_ff.dx) : abs_diff(job_ff.dz);
   assign prod  = 34'(slope_scale) * 34'(mul_d);
   assign sq_op = (state_ff == BK_SQ_X) ? ax_ff : az_ff;
   assign sq    = 62'(sq_op) * 62'(sq_op);

   assign trial   = res_ff + bit_ff;
   assign root_ge = (n_ff >= trial);
   assign root    = res_ff[31:0];

   always_comb begin
      case (comp_ff)
         COMP_X:  mag = ax_ff;
         COMP_Y:  mag = UP_MAG;
         default: mag = az_ff;
      endcase
   end

   assign div_ge  = (rem_ff >= dv_ff);
   assign q_next  = {q_ff[13:0], div_ge};
   assign div_end = (state_ff == BK_DIV) && (cnt_ff == 5'd14);
   assign load_out = (state_ff == BK_DONE) && (!out_valid_ff || rsp_if.ready);
   assign pop_ready = (state_ff == BK_IDLE);

   always_comb begin
      if ((comp_ff == COMP_X && job_ff.dx[17]) || (comp_ff == COMP_Z && job_ff.dz[17])) begin
         q_signed = 16'd0 - 16'(q_next);
      end else begin
         q_signed = 16'(q_next);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               state_in = BK_MUL_X;
            end
         end
         BK_MUL_X:    state_in = BK_MUL_Z;
         BK_MUL_Z:    state_in = BK_SQ_X;
         BK_SQ_X:     state_in = BK_SQ_Z;
         BK_SQ_Z:     state_in = BK_SUM;
         BK_SUM:      state_in = BK_ROOT;
         BK_ROOT: begin
            if (cnt_ff == 5'd31) begin
               state_in = BK_DIV_LOAD;
            end
         end
         BK_DIV_LOAD: state_in = BK_DIV;
         BK_DIV: begin
            if (div_end) begin
               state_in = (comp_ff == COMP_Z) ? BK_DONE : BK_DIV_LOAD;
            end
         end
         BK_DONE: begin
            if (load_out) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         BK_IDLE: begin
            job_ff <= pop_job;
         end
         BK_MUL_X: begin
            ax_ff <= prod[32:2];
         end
         BK_MUL_Z: begin
            az_ff <= prod[32:2];
         end
         BK_SQ_X: begin
            sq_ff <= sq;
         end
         BK_SQ_Z: begin
            acc_ff <= 64'(sq_ff) + UP_SQ;
            sq_ff  <= sq;
         end
         BK_SUM: begin
            n_ff    <= acc_ff + 64'(sq_ff);
            res_ff  <= '0;
            bit_ff  <= BIT_INIT;
            cnt_ff  <= '0;
            comp_ff <= COMP_X;
         end
         BK_ROOT: begin
            if (root_ge) begin
               n_ff   <= n_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff + 5'd1;
         end
         BK_DIV_LOAD: begin
            rem_ff <= 46'({mag, 14'd0}) + 46'(root >> 1);
            dv_ff  <= {root, 14'd0};
            q_ff   <= '0;
            cnt_ff <= '0;
         end
         BK_DIV: begin
            if (div_ge) begin
               rem_ff <= rem_ff - dv_ff;
            end
            dv_ff  <= dv_ff >> 1;
            q_ff   <= q_next;
            cnt_ff <= cnt_ff + 5'd1;
            if (div_end) begin
               comp_ff <= comp_ff + 2'd1;
               case (comp_ff)
                  COMP_X:  nx_ff <= q_signed;
                  COMP_Y:  ny_ff <= q_next;
                  default: nz_ff <= q_signed;
               endcase
            end
         end
         BK_DONE: begin
            if (load_out) begin
               out_x_ff    <= $signed(nx_ff);
               out_y_ff    <= ny_ff;
               out_z_ff    <= $signed(nz_ff);
               out_col_ff  <= job_ff.col;
               out_row_ff  <= job_ff.row;
               out_last_ff <= job_ff.last;
               out_eom_ff  <= job_ff.eom;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.normal_x    = out_x_ff;
   assign rsp_if.normal_y    = out_y_ff;
   assign rsp_if.normal_z    = out_z_ff;
   assign rsp_if.cell_column = out_col_ff;
   assign rsp_if.cell_row    = out_row_ff;
   assign rsp_if.last_of_run = out_last_ff;
   assign rsp_if.end_of_map  = out_eom_ff;

   a_up_positive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_y_ff != '0)
      else $error("up component of normal is zero");

   a_root_runs_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_DIV_LOAD |-> bit_ff == '0)
      else $error("root iteration ended early");
endmodule

// File: sv/heightmap_normal_generation.sv
// top level of the heightmap normal generator: register file and block wiring
//
// Height samples enter as beats on req_if in raster order, one per cell. For
// each sample the block emits zero to four normals on rsp_if: the cell one row
// up and one column left, the cell one row up at the last column, and on the
// last row the cells of that row itself. last_of_run marks the final normal of
// a sample and end_of_map the bottom right cell.
// The front end takes one sample at a time: it does the read-modify-write of the
// line store ram, then steps through the four possible normal slots, and takes
// no new sample until it is past the last slot. The back end works on one
// normal at a time: a 32 step bit-serial square root and three 15 step
// divisions. A four-entry job queue lets the front run ahead of the back.
// A stalled rsp_if holds its beat; the back end finishes the next normal and
// waits, and the queue then fills and stops req_if.
// Reset clears counters and window; the line stores are not cleared and need
// no clearing pass. The user must see that registers are written over the APB
// port only while idle; the block itself does not enforce this.
`timescale 1ns / 1ps
module heightmap_normal_generation #(
   parameter int MAX_WIDTH = hmng_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   hmng_req_if.sink                            req_if,
   hmng_rsp_if.source                          rsp_if,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [hmng_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [hmng_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [hmng_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready
);
   import hmng_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   logic [MAP_WIDTH_BITS-1:0]  map_width_ff;
   logic [MAP_HEIGHT_BITS-1:0] map_height_ff;
   logic [SCALE_BITS-1:0]      slope_scale_ff;
   logic                       csr_write;

   logic                       ram_we;
   logic [CW-1:0]              ram_waddr, ram_raddr;
   logic [2*SAMPLE_BITS-1:0]   ram_wdata, ram_rdata;
   logic                       push_valid, push_ready, pop_valid, pop_ready;
   hmng_job_type               push_job, pop_job;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff   <= MAP_WIDTH_RESET;
         map_height_ff  <= MAP_HEIGHT_RESET;
         slope_scale_ff <= SLOPE_SCALE_RESET;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            REG_MAP_WIDTH:   map_width_ff   <= pwdata[MAP_WIDTH_BITS-1:0];
            REG_MAP_HEIGHT:  map_height_ff  <= pwdata[MAP_HEIGHT_BITS-1:0];
            REG_SLOPE_SCALE: slope_scale_ff <= pwdata[SCALE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_MAP_WIDTH:   prdata = CSR_DATA_BITS'(map_width_ff);
         REG_MAP_HEIGHT:  prdata = CSR_DATA_BITS'(map_height_ff);
         REG_SLOPE_SCALE: prdata = CSR_DATA_BITS'(slope_scale_ff);
         default:         prdata = '0;
      endcase
   end

   hmng_ram #(
      .WIDTH (2*SAMPLE_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   hmng_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .map_width  (map_width_ff),
      .map_height (map_height_ff),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   hmng_queue #(
      .DEPTH (JOB_QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   hmng_back u_back (
      .clock       (clock),
      .reset       (reset),
      .slope_scale (slope_scale_ff),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_job     (pop_job),
      .rsp_if      (rsp_if)
   );
endmodule

// File: dv/testbench.sv
// self-checking testbench for the heightmap normal generator
`timescale 1ns / 1ps
module testbench;
   import hmng_pkg::*;

   typedef struct packed {
      logic signed [15:0] nx;
      logic [14:0]        ny;
      logic signed [15:0] nz;
      logic [9:0]         col;
      logic [15:0]        row;
      logic               last;
      logic               eom;
   } normal_type;

   typedef struct packed {
      logic [15:0] sample;
      logic        flat;
   } stim_row_type;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE      = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic pready;
   logic sample_flat = 1'b0;

   hmng_req_if req_bus();
   hmng_rsp_if rsp_bus();

   heightmap_normal_generation uut (
      .clock(clock), .reset(reset), .req_if(req_bus), .rsp_if(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [15:0] row_older [MAX_WIDTH_DEFAULT];
   logic [15:0] row_newer [MAX_WIDTH_DEFAULT];
   logic [15:0] left_win [4];
   int unsigned col_cnt, row_cnt;
   int unsigned cfg_width = MAP_WIDTH_RESET;
   int unsigned cfg_height = MAP_HEIGHT_RESET;
   int unsigned cfg_scale = SLOPE_SCALE_RESET;

   normal_type normals_due[$];
   int errors = 0;
   int cycles = 0;
   int stall_mode = 0;
   int random_items = 0;

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   function automatic longint unsigned root_floor(input longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] unit_comp(input longint unsigned mag,
                                             input longint unsigned rt, input bit neg);
      longint unsigned q;
      q = ((mag << 14) + (rt >> 1)) / rt;
      if (neg) q = 64'd0 - q;
      return q[15:0];
   endfunction

   function automatic normal_type normal_of(input int unsigned x, input int unsigned y,
         input int unsigned w, input int unsigned h,
         input int zl, input int zc, input int zr, input int zu, input int zd);
      normal_type n;
      int dx, dz;
      longint unsigned ax, az, b, rt;
      logic [15:0] up;
      if (x == 0) dx = 2 * (zc - zr);
      else if (x == w - 1) dx = 2 * (zl - zc);
      else dx = zl - zr;
      if (y == 0) dz = 2 * (zd - zc);
      else if (y == h - 1) dz = 2 * (zc - zu);
      else dz = zd - zu;
      ax = (longint'(cfg_scale) * longint'(dx < 0 ? -dx : dx)) >> 2;
      az = (longint'(cfg_scale) * longint'(dz < 0 ? -dz : dz)) >> 2;
      b = 64'd1 << 23;
      rt = root_floor(ax * ax + b * b + az * az);
      up = unit_comp(b, rt, 1'b0);
      n.nx = unit_comp(ax, rt, dx < 0);
      n.ny = up[14:0];
      n.nz = unit_comp(az, rt, dz < 0);
      n.col = x[9:0];
      n.row = y[15:0];
      n.last = 1'b0;
      n.eom = 1'b0;
      return n;
   endfunction

   task automatic predict_sample(input logic [15:0] smp, input logic flat);
      int unsigned w, h, c, r;
      int s, u, m, p;
      normal_type res[$];
      normal_type n;
      w = cfg_width;
      h = cfg_height;
      if (w < 2) w = 2;
      if (w > MAX_WIDTH_DEFAULT) w = MAX_WIDTH_DEFAULT;
      if (h < 2) h = 2;
      c = col_cnt > w - 1 ? w - 1 : col_cnt;
      r = row_cnt > h - 1 ? h - 1 : row_cnt;
      s = smp;
      u = row_older[c];
      m = row_newer[c];
      row_older[c] = m[15:0];
      row_newer[c] = smp;
      p = c >= 2 ? row_older[c - 2] : 0;
      if (r >= 1 && c >= 1)
         res.push_back(normal_of(c - 1, r - 1, w, h, p, left_win[1], m, left_win[0],
                                 left_win[2]));
      if (r >= 1 && c == w - 1)
         res.push_back(normal_of(c, r - 1, w, h, left_win[1], m, 0, u, s));
      if (r == h - 1 && c >= 1)
         res.push_back(normal_of(c - 1, r, w, h, left_win[3], left_win[2], s,
                                 left_win[1], 0));
      if (r == h - 1 && c == w - 1) begin
         n = normal_of(c, r, w, h, left_win[2], s, 0, m, 0);
         n.eom = 1'b1;
         res.push_back(n);
      end
      if (res.size() > 0) res[res.size() - 1].last = 1'b1;
      foreach (res[i]) begin
         if (flat && (res[i].nx != 0 || res[i].ny != 15'd16384 || res[i].nz != 0))
            report($sformatf("flat cell (%0d,%0d) not straight up", res[i].col, res[i].row));
         normals_due.push_back(res[i]);
      end
      left_win[0] = u[15:0];
      left_win[1] = m[15:0];
      left_win[3] = left_win[2];
      left_win[2] = smp;
      if (c == w - 1) begin
         col_cnt = 0;
         row_cnt = (r == h - 1) ? 0 : r + 1;
      end else begin
         col_cnt = c + 1;
         row_cnt = r;
      end
   endtask

   always @(posedge clock) begin
      normal_type got, want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            predict_sample(req_bus.height_sample, sample_flat);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.normal_x, rsp_bus.normal_y, rsp_bus.normal_z,
                    rsp_bus.cell_column, rsp_bus.cell_row, rsp_bus.last_of_run,
                    rsp_bus.end_of_map};
            if (normals_due.size() == 0) begin
               report($sformatf("unexpected beat col %0d row %0d", got.col, got.row));
            end else begin
               want = normals_due.pop_front();
               if (got.nx != want.nx) report($sformatf("normal_x %0d want %0d (%0d,%0d)",
                  got.nx, want.nx, want.col, want.row));
               if (got.ny != want.ny) report($sformatf("normal_y %0d want %0d (%0d,%0d)",
                  got.ny, want.ny, want.col, want.row));
               if (got.nz != want.nz) report($sformatf("normal_z %0d want %0d (%0d,%0d)",
                  got.nz, want.nz, want.col, want.row));
               if (got.col != want.col) report($sformatf("cell_column %0d want %0d",
                  got.col, want.col));
               if (got.row != want.row) report($sformatf("cell_row %0d want %0d",
                  got.row, want.row));
               if (got.last != want.last) report($sformatf("last_of_run %0d at (%0d,%0d)",
                  got.last, want.col, want.row));
               if (got.eom != want.eom) report($sformatf("end_of_map %0d at (%0d,%0d)",
                  got.eom, want.col, want.row));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // sink side stalls
   int hold = 0;
   always @(negedge clock) begin
      if (hold > 0) begin
         rsp_bus.ready = 1'b0;
         hold--;
      end else if (stall_mode == 0) begin
         rsp_bus.ready = 1'b1;
      end else begin
         rsp_bus.ready = 1'b1;
         if ($urandom_range(0, 99) < 20) hold = $urandom_range(1, 3);
         else if ($urandom_range(0, 99) < 3) hold = $urandom_range(20, 120);
      end
   end

   task automatic csr_access(input logic wr, input logic [1:0] idx,
                             input logic [31:0] val, output logic [31:0] rd);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = wr;
      paddr = {idx, 2'b00};
      pwdata = val;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rd = prdata;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      logic [31:0] rd, mask;
      csr_access(1'b1, idx, val, rd);
      case (idx)
         REG_MAP_WIDTH: begin
            cfg_width = val[10:0];
            mask = 32'h7ff;
         end
         REG_MAP_HEIGHT: begin
            cfg_height = val[15:0];
            mask = 32'hffff;
         end
         REG_SLOPE_SCALE: begin
            cfg_scale = val[15:0];
            mask = 32'hffff;
         end
         default: mask = 32'h0;
      endcase
      if (mask != 0) begin
         csr_access(1'b0, idx, 32'h0, rd);
         if ((rd & mask) != (val & mask))
            report($sformatf("register %0d reads %0h want %0h", idx, rd, val & mask));
      end
   endtask

   task automatic wait_idle();
      while (normals_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_map(input int w, input int h, input int s);
      wait_idle();
      csr_write(REG_MAP_WIDTH, w);
      csr_write(REG_MAP_HEIGHT, h);
      csr_write(REG_SLOPE_SCALE, s);
   endtask

   task automatic send_sample(input logic [15:0] smp, input logic flat);
      int gap, pick;
      pick = $urandom_range(0, 99);
      if (stall_mode == 0) gap = 0;
      else if (pick < 65) gap = 0;
      else if (pick < 95) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 60);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.height_sample = smp;
      sample_flat = flat;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_bus.valid = 1'b0;
      sample_flat = 1'b0;
   endtask

   task automatic random_map(input int w, input int h, input int s);
      int base;
      set_map(w, h, s);
      stall_mode = $urandom_range(0, 3) != 0;
      base = $urandom_range(0, 65535);
      for (int i = 0; i < w * h; i++) begin
         if ($urandom_range(0, 3) == 0) send_sample(16'($urandom_range(0, 65535)), 1'b0);
         else send_sample(16'((base + $urandom_range(0, 512) * i) & 16'hffff), 1'b0);
         random_items++;
      end
      end_burst();
   endtask

   stim_row_type dir_rows [17] = '{
      '{16'h0000, 1'b0}, '{16'hffff, 1'b0}, '{16'hffff, 1'b0}, '{16'h0000, 1'b0},
      '{16'h8000, 1'b1}, '{16'h8000, 1'b1}, '{16'h8000, 1'b1}, '{16'h8000, 1'b1},
      '{16'h0000, 1'b0}, '{16'h1000, 1'b0}, '{16'h2000, 1'b0},
      '{16'h5555, 1'b0}, '{16'haaaa, 1'b0}, '{16'h0001, 1'b0},
      '{16'hfffe, 1'b0}, '{16'h7fff, 1'b0}, '{16'hffff, 1'b0}
   };
   int dir_w [3] = '{2, 2, 3};
   int dir_h [3] = '{2, 2, 3};
   int dir_s [3] = '{65535, 256, 12800};

   initial begin
      int k, w, h, sc;
      req_bus.valid = 1'b0;
      req_bus.height_sample = '0;
      rsp_bus.ready = 1'b0;
      foreach (row_older[i]) begin
         row_older[i] = '0;
         row_newer[i] = '0;
      end
      foreach (left_win[i]) left_win[i] = '0;
      col_cnt = 0;
      row_cnt = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed maps walked from the table
      csr_write(REG_MAP_HEIGHT, 65535);
      csr_write(2'd3, 32'hffff_ffff);
      k = 0;
      for (int mp = 0; mp < 3; mp++) begin
         set_map(dir_w[mp], dir_h[mp], dir_s[mp]);
         for (int i = 0; i < dir_w[mp] * dir_h[mp]; i++) begin
            send_sample(dir_rows[k].sample, dir_rows[k].flat);
            k++;
         end
         end_burst();
      end

      // out of range sizes clamp
      stall_mode = 1;
      set_map(0, 0, 0);
      for (int i = 0; i < 4; i++) send_sample(16'($urandom_range(0, 65535)), 1'b0);
      end_burst();
      set_map(5, 1, 300);
      for (int i = 0; i < 10; i++) send_sample(16'($urandom_range(0, 65535)), 1'b0);
      end_burst();

      // random maps
      while (random_items < 190) begin
         w = $urandom_range(0, 9) == 0 ? $urandom_range(9, 40) : $urandom_range(2, 8);
         h = w > 8 ? 2 : $urandom_range(2, 6);
         k = $urandom_range(0, 4);
         sc = k == 0 ? 0 : k == 1 ? 65535 : $urandom_range(0, 65535);
         random_map(w, h, sc);
      end

      wait_idle();
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

// File: filelist.f
sv/hmng_pkg.sv
sv/hmng_if.sv
sv/hmng_ram.sv
sv/hmng_front.sv
sv/hmng_queue.sv
sv/hmng_back.sv
sv/heightmap_normal_generation.sv
dv/testbench.sv
